// ----- design/pfc_pkg.sv -----
// Shared types, codes and helpers for the Playfair digram cipher.
// Used by pfc_ctrl, pfc_datapath and playfair_digram_cipher_top; no dependencies.
package pfc_pkg;

	typedef struct packed {
		logic [1:0] command;
		logic [7:0] byte_a;
		logic [7:0] byte_b;
	} pfc_in_t;

	typedef struct packed {
		logic [7:0] cipher_a;
		logic [7:0] cipher_b;
		logic [1:0] status;
		logic [4:0] letters_placed;
	} pfc_out_t;

	// Commands carried in the command field.
	localparam logic [1:0] CMD_CLEAR   = 2'd0;
	localparam logic [1:0] CMD_KEY     = 2'd1;
	localparam logic [1:0] CMD_FINISH  = 2'd2;
	localparam logic [1:0] CMD_ENCRYPT = 2'd3;

	// Result status codes.
	localparam logic [1:0] ST_DONE       = 2'd0;
	localparam logic [1:0] ST_IGNORED    = 2'd1;
	localparam logic [1:0] ST_NOT_READY  = 2'd2;
	localparam logic [1:0] ST_BAD_LETTER = 2'd3;

	localparam logic [7:0] LETTER_BASE = 8'd97;   // 'a'
	localparam logic [7:0] LETTER_LAST = 8'd122;  // 'z'
	localparam logic [7:0] LETTER_J    = 8'd106;  // 'j'
	localparam logic [7:0] UPPER_A     = 8'd65;
	localparam logic [7:0] UPPER_Z     = 8'd90;
	localparam logic [7:0] CASE_GAP    = 8'd32;
	localparam logic [4:0] CELLS       = 5'd25;
	localparam logic [4:0] LAST_LETTER = 5'd25;
	localparam logic [4:0] J_INDEX     = 5'd9;
	localparam logic [4:0] I_INDEX     = 5'd8;
	localparam logic [2:0] LAST_POS    = 3'd4;

	// Command and status groups between the controller and the datapath.
	typedef struct packed {
		logic accept;     // latch the input word, read letter positions
		logic exec;       // carry out the command's first step
		logic fill_step;  // examine one letter of the finishing walk
		logic cell_out;   // ciphertext letters are ready in the read registers
		logic out_load;   // write the result register
	} pfc_ctl_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       ready;
		logic       digram_ok;
		logic       fill_last;
	} pfc_sts_t;

	// Split a cell number 0..24 into {row, column}.
	function automatic logic [5:0] cell_rc(input logic [4:0] cell_num);
		logic [2:0] row;
		logic [4:0] rem;
		begin
			if (cell_num >= 5'd20) begin
				row = 3'd4;
				rem = cell_num - 5'd20;
			end else if (cell_num >= 5'd15) begin
				row = 3'd3;
				rem = cell_num - 5'd15;
			end else if (cell_num >= 5'd10) begin
				row = 3'd2;
				rem = cell_num - 5'd10;
			end else if (cell_num >= 5'd5) begin
				row = 3'd1;
				rem = cell_num - 5'd5;
			end else begin
				row = 3'd0;
				rem = cell_num;
			end
			return {row, rem[2:0]};
		end
	endfunction

	// Cell number from row and column: row * 5 + column.
	function automatic logic [4:0] rc_cell(input logic [2:0] row, input logic [2:0] col);
		return 5'({row, 2'b00}) + 5'(row) + 5'(col);
	endfunction

	// Next row or column with wrap around the square.
	function automatic logic [2:0] wrap_inc(input logic [2:0] pos);
		return (pos == LAST_POS) ? 3'd0 : pos + 3'd1;
	endfunction

endpackage

// ----- design/playfair_digram_cipher_top.sv -----
// Top level of the Playfair digram cipher: controller, datapath and checks.
// Depends on pfc_pkg, pfc_ctrl and pfc_datapath.
//
//   channel | handshake           | word
//   --------+---------------------+--------------------------------------------
//   in      | in_valid, in_ready  | command, byte_a, byte_b
//   out     | out_valid, out_ready| cipher_a, cipher_b, status, letters_placed
//
// Each input word gives exactly one output word. Clear, key byte, a finish
// on an already complete square and an encrypt that fails are accepted, then
// executed and delivered together. A successful encrypt reads the two letter
// positions, then the two target cells of the key square, then delivers.
// Finishing the square walks all 26 letters one per cycle.
// Reset clears the letter set, fill count and ready flag; the tables need no
// clearing. A word may be accepted while the previous result still waits;
// the execute step, and the last step of a finish or a successful encrypt,
// hold while the output still has a word that is not being taken.
module playfair_digram_cipher_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  pfc_pkg::pfc_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output pfc_pkg::pfc_out_t out_data
);
	import pfc_pkg::*;

	// The controller sees only command-level status; the datapath sees only
	// the step commands, so all sequencing lives in one place.
	pfc_ctl_t ctl;
	pfc_sts_t sts;

	pfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pfc_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.ctl      (ctl),
		.sts      (sts),
		.out_data (out_data)
	);

	// After a word is taken, in_ready is low in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("input taken again right after an accept");

	// Ciphertext appears only with a done status.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.cipher_a != 8'd0 || out_data.cipher_b != 8'd0)
		|-> out_data.status == ST_DONE)
	else $error("ciphertext with a failure status");

	// A successful encryption needs a full square.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.cipher_a != 8'd0 |-> out_data.letters_placed == CELLS)
	else $error("ciphertext from an incomplete square");

	// The fill count never passes the square size.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.letters_placed <= CELLS)
	else $error("fill count beyond the square");

endmodule

// ----- design/pfc_ctrl.sv -----
// Sequencing state machine for the Playfair digram cipher.
// Depends on pfc_pkg; drives pfc_datapath through pfc_ctl_t.
module pfc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  pfc_pkg::pfc_sts_t sts,
	output pfc_pkg::pfc_ctl_t ctl
);
	import pfc_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_FILL = 2'd2;
	localparam logic [1:0] S_CELL = 2'd3;

	logic [1:0] state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.accept = 1'b1;
					state_nxt  = S_EXEC;
				end
			end
			S_EXEC: begin
				if (out_free) begin
					ctl.exec = 1'b1;
					if (sts.cmd == CMD_FINISH && !sts.ready) begin
						state_nxt = S_FILL;
					end else if (sts.cmd == CMD_ENCRYPT && sts.ready && sts.digram_ok) begin
						state_nxt = S_CELL;
					end else begin
						ctl.out_load = 1'b1;
						state_nxt    = S_IDLE;
					end
				end
			end
			S_FILL: begin
				if (!sts.fill_last || out_free) begin
					ctl.fill_step = 1'b1;
					if (sts.fill_last) begin
						ctl.out_load = 1'b1;
						state_nxt    = S_IDLE;
					end
				end
			end
			S_CELL: begin
				if (out_free) begin
					ctl.cell_out = 1'b1;
					ctl.out_load = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- design/pfc_datapath.sv -----
// Key square storage, letter bookkeeping and digram mapping for the cipher.
// Depends on pfc_pkg; commanded by pfc_ctrl through pfc_ctl_t.
module pfc_datapath (
	input  logic              clk,
	input  logic              arst_n,
	input  pfc_pkg::pfc_in_t  in_data,
	input  pfc_pkg::pfc_ctl_t ctl,
	output pfc_pkg::pfc_sts_t sts,
	output pfc_pkg::pfc_out_t out_data
);
	import pfc_pkg::*;

	// Cell of each letter and letter of each cell, written as the square fills.
	logic [4:0] letter_cell [26];
	logic [4:0] key_square  [25];

	logic [1:0]  cmd_q;
	logic [7:0]  a_q, b_q;
	logic [25:0] used_q;
	logic [4:0]  fill_q, fill_nxt;
	logic        ready_q;
	logic [4:0]  k_q;
	logic [4:0]  pa_q, pb_q;
	logic [4:0]  ks_a_q, ks_b_q;
	pfc_out_t    out_q;

	logic [7:0] in_off_a, in_off_b;
	logic [4:0] rd_addr_a, rd_addr_b;
	logic       digram_a_ok, digram_b_ok;

	logic [7:0] key_char;
	logic       key_letter;
	logic [4:0] key_off, key_idx;
	logic       key_ok, key_place, fill_place;

	logic       we;
	logic [4:0] w_letter;

	logic [2:0] ra, ca, rb, cb;
	logic [4:0] cell_a, cell_b;

	logic [1:0] exec_status;
	pfc_out_t   res;

	// Letter positions are looked up straight from the incoming word.
	assign in_off_a  = in_data.byte_a - LETTER_BASE;
	assign in_off_b  = in_data.byte_b - LETTER_BASE;
	assign rd_addr_a = (in_data.byte_a >= LETTER_BASE && in_data.byte_a <= LETTER_LAST)
		? in_off_a[4:0] : 5'd0;
	assign rd_addr_b = (in_data.byte_b >= LETTER_BASE && in_data.byte_b <= LETTER_LAST)
		? in_off_b[4:0] : 5'd0;

	assign digram_a_ok = a_q >= LETTER_BASE && a_q <= LETTER_LAST && a_q != LETTER_J;
	assign digram_b_ok = b_q >= LETTER_BASE && b_q <= LETTER_LAST && b_q != LETTER_J;

	// Key byte: fold upper case, drop non-letters, j goes to i.
	always_comb begin
		key_char   = (a_q >= UPPER_A && a_q <= UPPER_Z) ? a_q + CASE_GAP : a_q;
		key_letter = key_char >= LETTER_BASE && key_char <= LETTER_LAST;
		key_off    = 5'(key_char - LETTER_BASE);
		key_idx    = (key_off == J_INDEX) ? I_INDEX : key_off;
		key_ok     = !ready_q && key_letter && !used_q[key_idx];
		key_place  = key_ok && fill_q < CELLS;
		fill_place = k_q != J_INDEX && !used_q[k_q] && fill_q < CELLS;
	end

	assign we       = (ctl.exec && cmd_q == CMD_KEY && key_place) || (ctl.fill_step && fill_place);
	assign w_letter = ctl.exec ? key_idx : k_q;

	always_comb begin
		fill_nxt = fill_q;
		if (ctl.exec && cmd_q == CMD_CLEAR) begin
			fill_nxt = 5'd0;
		end else if (we) begin
			fill_nxt = fill_q + 5'd1;
		end
	end

	// Digram rules on the looked-up cells.
	always_comb begin
		{ra, ca} = cell_rc(pa_q);
		{rb, cb} = cell_rc(pb_q);
		priority if (ra == rb) begin
			cell_a = rc_cell(ra, wrap_inc(ca));
			cell_b = rc_cell(rb, wrap_inc(cb));
		end else if (ca == cb) begin
			cell_a = rc_cell(wrap_inc(ra), ca);
			cell_b = rc_cell(wrap_inc(rb), cb);
		end else begin
			cell_a = rc_cell(ra, cb);
			cell_b = rc_cell(rb, ca);
		end
	end

	always_comb begin
		unique case (cmd_q)
			CMD_KEY:     exec_status = key_ok ? ST_DONE : ST_IGNORED;
			CMD_ENCRYPT: exec_status = !ready_q ? ST_NOT_READY :
				(digram_a_ok && digram_b_ok) ? ST_DONE : ST_BAD_LETTER;
			default:     exec_status = ST_DONE;
		endcase
	end

	always_comb begin
		res                = '0;
		res.letters_placed = fill_nxt;
		if (ctl.cell_out) begin
			res.cipher_a = LETTER_BASE + {3'b000, ks_a_q};
			res.cipher_b = LETTER_BASE + {3'b000, ks_b_q};
			res.status   = ST_DONE;
		end else if (ctl.exec) begin
			res.status = exec_status;
		end else begin
			res.status = ST_DONE;
		end
	end

	// Memories and payload registers.
	always_ff @(posedge clk) begin
		if (we) begin
			key_square[fill_q]    <= w_letter;
			letter_cell[w_letter] <= fill_q;
		end
		if (ctl.accept) begin
			cmd_q <= in_data.command;
			a_q   <= in_data.byte_a;
			b_q   <= in_data.byte_b;
			pa_q  <= letter_cell[rd_addr_a];
			pb_q  <= letter_cell[rd_addr_b];
		end
		if (ctl.exec) begin
			ks_a_q <= key_square[cell_a];
			ks_b_q <= key_square[cell_b];
		end
		if (ctl.out_load) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			fill_q  <= '0;
			ready_q <= 1'b0;
			k_q     <= '0;
		end else begin
			fill_q <= fill_nxt;
			if (ctl.exec && cmd_q == CMD_CLEAR) begin
				used_q  <= '0;
				ready_q <= 1'b0;
			end else if (we) begin
				used_q[w_letter] <= 1'b1;
			end
			if (ctl.exec) begin
				k_q <= '0;
			end else if (ctl.fill_step) begin
				k_q <= k_q + 5'd1;
				if (k_q == LAST_LETTER) begin
					ready_q <= 1'b1;
				end
			end
		end
	end

	assign sts.cmd       = cmd_q;
	assign sts.ready     = ready_q;
	assign sts.digram_ok = digram_a_ok && digram_b_ok;
	assign sts.fill_last = (k_q == LAST_LETTER);
	assign out_data      = out_q;

endmodule

// ----- tb/tb_playfair_digram_cipher_top.sv -----
// Self-checking testbench for playfair_digram_cipher_top: builds key squares, encrypts digrams
// and compares every output word with a cycle-free prediction of the cipher.
// Depends on pfc_pkg and the playfair_digram_cipher_top RTL.
module tb_playfair_digram_cipher_top;
	timeunit 1ns;
	timeprecision 1ps;

	import pfc_pkg::*;

	localparam int SIDE         = 5;
	localparam int NUM_LETTERS  = 26;
	localparam int NUM_CELLS    = 25;
	localparam int PHASE_WORDS  = 200;
	localparam int TAIL_CYCLES  = 40;
	localparam int CYCLE_LIMIT  = 400000;

	// The scoreboard keeps its own copy of the key square. Every accepted input
	// word is run through the cipher rules at once, and the resulting output
	// word waits in order until the block delivers its own.
	class playfair_scoreboard;
		logic [25:0] used_set;
		logic [4:0]  square [NUM_CELLS];
		logic [4:0]  cell_of [NUM_LETTERS];
		logic [4:0]  fill;
		logic        ready;
		pfc_out_t    pending_words [$];
		int unsigned errors;

		function new();
			used_set = '0;
			fill = '0;
			ready = 1'b0;
			errors = 0;
		endfunction

		function void place(input int idx);
			if (fill < NUM_CELLS) begin
				square[fill] = 5'(idx);
				cell_of[idx] = fill;
				used_set[idx] = 1'b1;
				fill = fill + 5'd1;
			end
		endfunction

		function bit letter_ok(input logic [7:0] b);
			return b >= LETTER_BASE && b <= LETTER_LAST && b != LETTER_J;
		endfunction

		function logic [7:0] letter_at(input int row, input int col);
			return LETTER_BASE + 8'(square[(row % SIDE) * SIDE + (col % SIDE)]);
		endfunction

		function pfc_out_t cipher_step(input pfc_in_t w);
			pfc_out_t r;
			logic [7:0] c;
			int idx, pa, pb, ra, rb, ca, cb;
			r = '0;
			case (w.command)
				CMD_CLEAR: begin
					used_set = '0;
					fill = '0;
					ready = 1'b0;
				end
				CMD_KEY: begin
					c = w.byte_a;
					if (c >= UPPER_A && c <= UPPER_Z)
						c = c + CASE_GAP;
					if (ready || c < LETTER_BASE || c > LETTER_LAST) begin
						r.status = ST_IGNORED;
					end else begin
						idx = int'(c - LETTER_BASE);
						if (idx == J_INDEX)
							idx = I_INDEX;
						if (used_set[idx])
							r.status = ST_IGNORED;
						else
							place(idx);
					end
				end
				CMD_FINISH: begin
					if (!ready) begin
						for (int k = 0; k < NUM_LETTERS; k++)
							if (k != J_INDEX && !used_set[k])
								place(k);
						ready = 1'b1;
					end
				end
				default: begin
					if (!ready) begin
						r.status = ST_NOT_READY;
					end else if (!letter_ok(w.byte_a) || !letter_ok(w.byte_b)) begin
						r.status = ST_BAD_LETTER;
					end else begin
						pa = int'(cell_of[w.byte_a - LETTER_BASE]);
						pb = int'(cell_of[w.byte_b - LETTER_BASE]);
						ra = pa / SIDE;
						ca = pa % SIDE;
						rb = pb / SIDE;
						cb = pb % SIDE;
						if (ra == rb) begin
							r.cipher_a = letter_at(ra, ca + 1);
							r.cipher_b = letter_at(rb, cb + 1);
						end else if (ca == cb) begin
							r.cipher_a = letter_at(ra + 1, ca);
							r.cipher_b = letter_at(rb + 1, cb);
						end else begin
							r.cipher_a = letter_at(ra, cb);
							r.cipher_b = letter_at(rb, ca);
						end
					end
				end
			endcase
			r.letters_placed = fill;
			return r;
		endfunction

		function void note_word(input pfc_in_t w);
			pending_words.push_back(cipher_step(w));
		endfunction

		function void check_word(input pfc_out_t got);
			pfc_out_t exp;
			if (pending_words.size() == 0) begin
				$error("output word with none expected: %0h", got);
				errors++;
				return;
			end
			exp = pending_words.pop_front();
			if (got.cipher_a !== exp.cipher_a) begin
				$error("cipher_a: expected %0h, got %0h", exp.cipher_a, got.cipher_a);
				errors++;
			end
			if (got.cipher_b !== exp.cipher_b) begin
				$error("cipher_b: expected %0h, got %0h", exp.cipher_b, got.cipher_b);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, got %0d", exp.status, got.status);
				errors++;
			end
			if (got.letters_placed !== exp.letters_placed) begin
				$error("letters_placed: expected %0d, got %0d",
					exp.letters_placed, got.letters_placed);
				errors++;
			end
		endfunction
	endclass

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	pfc_in_t  in_data;
	logic     out_valid;
	logic     out_ready = 1'b0;
	pfc_out_t out_data;

	playfair_scoreboard sb;
	int unsigned send_idle_pct = 11;
	int unsigned recv_idle_pct = 59;
	int unsigned word_count;
	int unsigned cycle_count;

	playfair_digram_cipher_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog. A correct run ends long before this count; hitting it means
	// the block has hung on one of its handshakes.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_playfair_digram_cipher_top: FAIL");
		$finish;
	end

	// Output side. The handshake is sampled right at the edge, before the
	// block's own registers update, and the ready for the next cycle is drawn
	// at random according to the current idle rate.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_word(out_data);
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic [7:0] rand_byte();
		return 8'($urandom_range(255));
	endfunction

	// A lowercase letter that can appear in the square, so never j.
	function automatic logic [7:0] rand_letter();
		int idx;
		idx = $urandom_range(24);
		if (idx >= J_INDEX)
			idx++;
		return LETTER_BASE + 8'(idx);
	endfunction

	// Key bytes are mostly letters of either case, with some arbitrary bytes
	// that the block must drop.
	function automatic logic [7:0] key_byte();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return LETTER_BASE + 8'($urandom_range(25));
		else if (r < 85)
			return UPPER_A + 8'($urandom_range(25));
		return rand_byte();
	endfunction

	// Offers one input word. Valid stays low through a random number of idle
	// cycles, then rises and holds until the block takes the word. It is not
	// lowered after acceptance, so back-to-back words keep valid high.
	task automatic send_word(input logic [1:0] cmd, input logic [7:0] a,
			input logic [7:0] b);
		pfc_in_t w;
		w.command = cmd;
		w.byte_a = a;
		w.byte_b = b;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_word(w);
		word_count++;
	endtask

	// Holds the input side quiet until every expected output word has come.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		while (sb.pending_words.size() != 0)
			@(posedge clk);
	endtask

	// Directed opening: encrypt on an empty square, a key with mixed case, a
	// j that folds onto an existing i, a digit, a repeat, the byte extremes,
	// a double finish, a key byte after the square is done, and digrams that
	// hit each rule and each kind of bad letter.
	task automatic run_directed();
		send_word(CMD_ENCRYPT, "p", "l");
		send_word(CMD_CLEAR, 8'h00, 8'hFF);
		send_word(CMD_KEY, "P", rand_byte());
		send_word(CMD_KEY, "L", rand_byte());
		send_word(CMD_KEY, "a", rand_byte());
		send_word(CMD_KEY, "y", rand_byte());
		send_word(CMD_KEY, "F", rand_byte());
		send_word(CMD_KEY, "i", rand_byte());
		send_word(CMD_KEY, "R", rand_byte());
		send_word(CMD_KEY, "J", rand_byte());
		send_word(CMD_KEY, "5", rand_byte());
		send_word(CMD_KEY, "a", rand_byte());
		send_word(CMD_KEY, 8'h00, 8'hFF);
		send_word(CMD_KEY, 8'hFF, 8'h00);
		send_word(CMD_KEY, "Z", rand_byte());
		send_word(CMD_FINISH, rand_byte(), rand_byte());
		send_word(CMD_FINISH, rand_byte(), rand_byte());
		send_word(CMD_KEY, "b", rand_byte());
		send_word(CMD_ENCRYPT, "p", "l");
		send_word(CMD_ENCRYPT, "p", "i");
		send_word(CMD_ENCRYPT, "h", "i");
		send_word(CMD_ENCRYPT, "e", "e");
		send_word(CMD_ENCRYPT, "j", "x");
		send_word(CMD_ENCRYPT, 8'h60, "a");
		send_word(CMD_ENCRYPT, "a", 8'h7B);
		send_word(CMD_ENCRYPT, "a", "z");
		send_word(CMD_ENCRYPT, "z", 8'hFF);
	endtask

	// One random key session: clear, a key (sometimes a full shuffled
	// alphabet that fills the square on its own), finish, then a run of
	// digrams. Some sessions encrypt too early, stop before finishing, finish
	// twice or push a key byte into a finished square.
	task automatic run_key_session();
		logic [7:0] deck [NUM_LETTERS];
		logic [7:0] tmp;
		int n, pick, r;
		send_word(CMD_CLEAR, rand_byte(), rand_byte());
		if ($urandom_range(5) == 0) begin
			for (int i = 0; i < NUM_LETTERS; i++)
				deck[i] = LETTER_BASE + 8'(i);
			for (int i = NUM_LETTERS - 1; i > 0; i--) begin
				pick = $urandom_range(i);
				tmp = deck[i];
				deck[i] = deck[pick];
				deck[pick] = tmp;
			end
			for (int i = 0; i < NUM_LETTERS; i++)
				send_word(CMD_KEY, $urandom_range(1) ? deck[i] : deck[i] - CASE_GAP,
					rand_byte());
		end else begin
			n = $urandom_range(12);
			repeat (n)
				send_word(CMD_KEY, key_byte(), rand_byte());
		end
		if ($urandom_range(7) == 0)
			send_word(CMD_ENCRYPT, rand_letter(), rand_letter());
		if ($urandom_range(9) == 0)
			return;
		send_word(CMD_FINISH, rand_byte(), rand_byte());
		if ($urandom_range(5) == 0)
			send_word(CMD_FINISH, rand_byte(), rand_byte());
		if ($urandom_range(5) == 0)
			send_word(CMD_KEY, key_byte(), rand_byte());
		n = $urandom_range(3, 12);
		repeat (n) begin
			r = $urandom_range(99);
			if (r < 5) begin
				tmp = rand_letter();
				send_word(CMD_ENCRYPT, tmp, tmp);
			end else if (r < 15) begin
				send_word(CMD_ENCRYPT, rand_byte(), rand_byte());
			end else begin
				send_word(CMD_ENCRYPT, rand_letter(), rand_letter());
			end
		end
	endtask

	// Main sequence. Reset is held low at the start, then the directed words
	// run, then three random phases with different idle patterns. Between
	// phases the sender waits for every outstanding output word.
	initial begin
		in_valid <= 1'b0;
		in_data <= '0;
		arst_n <= 1'b0;
		sb = new();
		word_count = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		drain_outputs();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 11;
					recv_idle_pct = 59;
				end
				1: begin
					send_idle_pct = 59;
					recv_idle_pct = 11;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			word_count = 0;
			while (word_count < PHASE_WORDS)
				run_key_session();
			drain_outputs();
		end

		// A finish walk is the longest operation, so this tail covers any
		// stray word the block might still emit.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.pending_words.size() == 0)
			$display("tb_playfair_digram_cipher_top: PASS");
		else
			$display("tb_playfair_digram_cipher_top: FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/pfc_pkg.sv
design/pfc_ctrl.sv
design/pfc_datapath.sv
design/playfair_digram_cipher_top.sv
tb/tb_playfair_digram_cipher_top.sv
